FILE: hdl/cdtmr_pkg.sv
// Shared types and constants for the countdown timer table.
`default_nettype none

package cdtmr_pkg;

    // Table geometry
    localparam int NUM_SLOTS   = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Fixed field widths of the channels
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int START_W = 32;
    localparam int KIND_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_OK        = 3'd0,
        K_NOSPACE   = 3'd1,
        K_INVALID   = 3'd2,
        K_NOTDONE   = 3'd3,
        K_EXPIRED   = 3'd4,
        K_TICKDONE  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_RUN     = 2'd1,
        ST_CANCEL  = 2'd2,
        ST_EXPIRED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_SLOT_OP,
        S_TICK_CHK,
        S_TICK_DEC,
        S_TICK_EVT,
        S_EMIT
    } fsm_t;

endpackage

`default_nettype wire

FILE: hdl/cdtmr_ifs.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface cdtmr_cmd_if;
    import cdtmr_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot_id;
    logic [START_W-1:0] start_count;

    modport source (output valid, output op, output slot_id, output start_count,
                    input ready);
    modport sink   (input valid, input op, input slot_id, input start_count,
                    output ready);
endinterface

interface cdtmr_rsp_if;
    import cdtmr_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_number;
    logic              last;

    modport source (output valid, output kind, output slot_number, output last,
                    input ready);
    modport sink   (input valid, input kind, input slot_number, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/multi_slot_countdown_timer_table_top.sv
// Add runs a lowest-free scan, one slot a cycle; cancel and release act on the named
// slot; tick walks every slot in order, and for a running slot reads its count from the
// count memory (a registered read), decrements it and writes it back, and for a slot
// that expires emits an expired beat before the closing beat. A result beat waits while
// the output register is still held. One command at a time; the next command is
// taken once the last result beat sits in the output register.
// Reset: all slots free; count memory is not cleared, its read data is used only for running slots.
`default_nettype none

module multi_slot_countdown_timer_table_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdtmr_cmd_if.sink  cmd,
    cdtmr_rsp_if.source rsp
);
    import cdtmr_pkg::*;

    // State and datapath registers
    fsm_t                   state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    kind_t                  res_kind_reg, res_kind_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;

    status_t                status_reg [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] count_mem  [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_last_reg;

    // Control
    logic                   cmd_fire;
    logic                   out_free;
    logic                   idx_last;
    logic                   cnt_zero;
    logic                   sid_oor;
    status_t                cur_status;
    logic [COUNT_WIDTH-1:0] dec_value;
    logic                   dec_zero;

    logic                   status_we;
    status_t                status_wdata;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   out_load;
    kind_t                  out_kind_d;
    logic [SLOT_W-1:0]      out_slot_d;
    logic                   out_last_d;

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign idx_last    = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign cnt_zero    = (cmd.start_count[COUNT_WIDTH-1:0] == '0);
    assign sid_oor     = ({3'b000, cmd.slot_id} >= 7'(NUM_SLOTS));
    assign cur_status  = status_reg[idx_reg];

    // Shared decrement unit
    assign dec_value   = rd_data_reg - COUNT_WIDTH'(1);
    assign dec_zero    = (dec_value == '0);

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.slot_number = out_slot_reg;
    assign rsp.last        = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (op_t'(cmd.op))
                        OP_ADD:     state_next = cnt_zero ? S_EMIT : S_ADD_SCAN;
                        OP_CANCEL,
                        OP_RELEASE: state_next = sid_oor ? S_EMIT : S_SLOT_OP;
                        OP_TICK:    state_next = S_TICK_CHK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN:
            begin
                if (cur_status == ST_FREE || idx_last)
                    state_next = S_EMIT;
            end
            S_SLOT_OP:
                state_next = S_EMIT;
            S_TICK_CHK:
            begin
                if (cur_status == ST_RUN)
                    state_next = S_TICK_DEC;
                else if (idx_last)
                    state_next = S_EMIT;
            end
            S_TICK_DEC:
            begin
                if (dec_zero)
                    state_next = S_TICK_EVT;
                else if (idx_last)
                    state_next = S_EMIT;
                else
                    state_next = S_TICK_CHK;
            end
            S_TICK_EVT:
            begin
                if (out_free)
                    state_next = idx_last ? S_EMIT : S_TICK_CHK;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        res_kind_next = res_kind_reg;
        res_slot_next = res_slot_reg;
        status_we     = 1'b0;
        status_wdata  = ST_FREE;
        mem_we        = 1'b0;
        mem_wdata     = cnt_reg;
        out_load      = 1'b0;
        out_kind_d    = res_kind_reg;
        out_slot_d    = res_slot_reg;
        out_last_d    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next  = op_t'(cmd.op);
                    cnt_next = cmd.start_count[COUNT_WIDTH-1:0];
                    case (op_t'(cmd.op))
                        OP_ADD:
                        begin
                            idx_next      = '0;
                            res_slot_next = '0;
                            res_kind_next = cnt_zero ? K_INVALID : K_NOSPACE;
                        end
                        OP_CANCEL,
                        OP_RELEASE:
                        begin
                            idx_next      = IDX_W'(cmd.slot_id);
                            res_slot_next = cmd.slot_id;
                            res_kind_next = K_INVALID;
                        end
                        OP_TICK:
                        begin
                            idx_next      = '0;
                            res_slot_next = '0;
                            res_kind_next = K_TICKDONE;
                        end
                        default:
                        begin
                            idx_next = '0;
                        end
                    endcase
                end
            end
            // Lowest free slot, one per cycle
            S_ADD_SCAN:
            begin
                if (cur_status == ST_FREE)
                begin
                    status_we     = 1'b1;
                    status_wdata  = ST_RUN;
                    mem_we        = 1'b1;
                    mem_wdata     = cnt_reg;
                    res_kind_next = K_OK;
                    res_slot_next = SLOT_W'(idx_reg);
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            // Cancel or release of an in-range slot
            S_SLOT_OP:
            begin
                if (cur_status != ST_FREE)
                begin
                    if (op_reg == OP_CANCEL)
                    begin
                        status_we     = 1'b1;
                        status_wdata  = ST_CANCEL;
                        res_kind_next = K_OK;
                    end
                    else if (cur_status == ST_RUN)
                    begin
                        res_kind_next = K_NOTDONE;
                    end
                    else
                    begin
                        status_we     = 1'b1;
                        status_wdata  = ST_FREE;
                        res_kind_next = K_OK;
                    end
                end
            end
            // Tick walk: count read is in flight when the slot runs
            S_TICK_CHK:
            begin
                if (cur_status != ST_RUN && !idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_TICK_DEC:
            begin
                mem_we    = 1'b1;
                mem_wdata = dec_value;
                if (dec_zero)
                begin
                    status_we    = 1'b1;
                    status_wdata = ST_EXPIRED;
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_TICK_EVT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind_d = K_EXPIRED;
                    out_slot_d = SLOT_W'(idx_reg);
                    out_last_d = 1'b0;
                    if (!idx_last)
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                    out_load = 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Slot status table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                status_reg[i] <= ST_FREE;
        end
        else if (status_we)
        begin
            status_reg[idx_reg] <= status_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        res_kind_reg <= res_kind_next;
        res_slot_reg <= res_slot_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_d;
            out_slot_reg <= out_slot_d;
            out_last_reg <= out_last_d;
        end
    end

    // Count memory, one port at the walk index, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            count_mem[idx_reg] <= mem_wdata;
        rd_data_reg <= count_mem[idx_reg];
    end

endmodule

`default_nettype wire
